// ===== src/lcr_pkg.sv =====
package lcr_pkg;

  // Bus constants
  localparam logic [6:0] DEV_ADDR    = 7'h33;
  localparam logic [7:0] REG_COLORS  = 8'h11;
  localparam logic [7:0] REG_TRANS   = 8'h10;
  localparam logic [7:0] TRANS_VALUE = 8'h05;
  localparam logic [7:0] CMD_PREFIX  = 8'h00;
  localparam logic [7:0] CMD_UPDATE  = 8'h01;

  // Configuration register indexes and reset values
  localparam logic CFG_UPDATE_RATE = 1'b0;
  localparam logic CFG_TICKS       = 1'b1;
  localparam logic [2:0]  RATE_RESET  = 3'd5;
  localparam logic [23:0] TICKS_RESET = 24'd1000;

  // Upper bound on the LED count and the index width that covers it
  localparam int MAX_LEDS  = 64;
  localparam int LED_IDX_W = 6;

  // One LED row: green in the low byte, then red, then blue
  typedef logic [23:0] row_t;
  typedef row_t palette_t [MAX_LEDS];

  // Build the reset palette, repeating the five base colours
  function automatic palette_t build_palette();
    palette_t   p;
    logic [2:0] c;
    c = 3'd0;
    for (int i = 0; i < MAX_LEDS; i++) begin
      unique case (c)
        3'd0:    p[i] = {8'd0,  8'd90, 8'd30};
        3'd1:    p[i] = {8'd0,  8'd40, 8'd0};
        3'd2:    p[i] = {8'd30, 8'd0,  8'd0};
        3'd3:    p[i] = {8'd5,  8'd85, 8'd5};
        default: p[i] = {8'd64, 8'd30, 8'd64};
      endcase
      c = (c == 3'd4) ? 3'd0 : c + 3'd1;
    end
    return p;
  endfunction

  localparam palette_t LED_PALETTE = build_palette();

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_HEAD,
    ST_BYTES,
    ST_PAIR_A,
    ST_PAIR_B
  } state_t;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_TRANS,
    PH_UPDATE
  } phase_t;

  typedef enum logic [2:0] {
    OUT_REG_COLORS,
    OUT_COLOR,
    OUT_REG_TRANS,
    OUT_TRANS_VALUE,
    OUT_PREFIX,
    OUT_UPDATE
  } out_sel_t;

  typedef struct packed {
    logic     load_item;
    logic     write_led;
    logic     fire;
    logic     out_load;
    out_sel_t out_sel;
    logic     rd_start;
    logic     rd_next;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_set;
    logic fires;
    logic out_free;
    logic row_done;
    logic run_done;
  } dp_stat_t;

endpackage

// ===== src/lcr_ctrl.sv =====
module lcr_ctrl
  import lcr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  state_t state, state_next;
  phase_t phase, phase_next;

  // State and phase registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_WAIT;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    phase_next = phase;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.out_sel = OUT_COLOR;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.is_set) begin
          cmd.write_led = 1'b1;
          state_next    = ST_IDLE;
        end else if (phase == PH_WAIT) begin
          if (stat.fires) begin
            cmd.fire   = 1'b1;
            phase_next = PH_TRANS;
            state_next = ST_HEAD;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_PAIR_A;
        end
      end
      ST_HEAD: begin
        // Send the colour register and fetch the first row
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_REG_COLORS;
          cmd.rd_start = 1'b1;
          state_next   = ST_BYTES;
        end
      end
      ST_BYTES: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_COLOR;
          if (stat.run_done) begin
            state_next = ST_IDLE;
          end else if (stat.row_done) begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      ST_PAIR_A: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = (phase == PH_TRANS) ? OUT_REG_TRANS : OUT_PREFIX;
          state_next   = ST_PAIR_B;
        end
      end
      ST_PAIR_B: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (phase == PH_TRANS) begin
            cmd.out_sel = OUT_TRANS_VALUE;
            phase_next  = PH_UPDATE;
          end else begin
            cmd.out_sel = OUT_UPDATE;
            phase_next  = PH_WAIT;
          end
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== src/lcr_datapath.sv =====
module lcr_datapath
  import lcr_pkg::*;
#(
  parameter int NUM_LEDS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] in_data,
  input  logic        in_user,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_wdata,
  input  ctl_cmd_t    cmd,
  output dp_stat_t    stat,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_first,
  output logic        out_last
);

  localparam int LW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [LW:0]   N_W   = (LW + 1)'(NUM_LEDS);
  localparam logic [LW-1:0] N_M1  = LW'(NUM_LEDS - 1);
  localparam logic [7:0]    N_B   = 8'(NUM_LEDS);

  // Configuration and derived threshold
  logic [2:0]  update_rate;
  logic [23:0] ticks_per_second;
  logic [26:0] limit;

  // Latched item
  logic        action_q;
  logic [31:0] now_q;
  logic [7:0]  led_q;
  logic [7:0]  red_q;
  logic [7:0]  green_q;
  logic [7:0]  blue_q;

  // Time and rotation state
  logic [31:0]   last_fire_time;
  logic [LW-1:0] rot;

  // Colour store and read side
  row_t          mem [NUM_LEDS];
  logic [NUM_LEDS-1:0] vld;
  row_t          rd_row;
  logic [LW-1:0] ptr;
  logic [LW-1:0] rd_addr;
  logic [LW-1:0] start_addr;
  logic [LW-1:0] wr_addr;
  logic [LW-1:0] led_m1;
  logic          led_ok;
  logic [1:0]    bsel;
  logic [LW-1:0] lcnt;
  logic [31:0]   elapsed;
  logic [7:0]    color_byte;
  logic [7:0]    byte_next;
  logic          first_next;
  logic          last_next;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      update_rate      <= RATE_RESET;
      ticks_per_second <= TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UPDATE_RATE: update_rate      <= cfg_wdata[2:0];
        CFG_TICKS:       ticks_per_second <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Register the firing threshold at full product width
  always_ff @(posedge clk) begin
    limit <= 27'(ticks_per_second) * 27'(update_rate);
  end

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      action_q <= in_user;
      now_q    <= in_data[31:0];
      led_q    <= in_data[39:32];
      red_q    <= in_data[47:40];
      green_q  <= in_data[55:48];
      blue_q   <= in_data[63:56];
    end
  end

  // Timing test and LED address translation
  always_comb begin
    elapsed = now_q - last_fire_time;
    led_ok  = (led_q != 8'd0) && (led_q <= N_B);
    led_m1  = LW'(led_q - 8'd1);
    if (led_m1 >= rot) begin
      wr_addr = led_m1 - rot;
    end else begin
      wr_addr = LW'({1'b0, led_m1} + N_W - {1'b0, rot});
    end
    start_addr = (rot == '0) ? '0 : LW'(N_W - {1'b0, rot});
    if (cmd.rd_start) begin
      rd_addr = start_addr;
    end else begin
      rd_addr = (ptr == N_M1) ? '0 : ptr + LW'(1);
    end
  end

  // Rotate by moving the read origin; record the firing time
  always_ff @(posedge clk) begin
    if (rst) begin
      last_fire_time <= '0;
      rot            <= '0;
    end else if (cmd.fire) begin
      last_fire_time <= now_q;
      rot            <= (rot == N_M1) ? '0 : rot + LW'(1);
    end
  end

  // Row valid bits: an unwritten row reads as its palette colour
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.write_led && led_ok) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Colour store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.write_led && led_ok) begin
      mem[wr_addr] <= {blue_q, red_q, green_q};
    end
    if (cmd.rd_start || cmd.rd_next) begin
      rd_row <= vld[rd_addr] ? mem[rd_addr] : LED_PALETTE[LED_IDX_W'(rd_addr)];
      ptr    <= rd_addr;
    end
  end

  // Byte and LED counters of a colour run
  always_ff @(posedge clk) begin
    if (cmd.rd_start) begin
      bsel <= 2'd0;
      lcnt <= '0;
    end else if (cmd.out_load && cmd.out_sel == OUT_COLOR) begin
      if (bsel == 2'd2) begin
        bsel <= 2'd0;
        lcnt <= lcnt + LW'(1);
      end else begin
        bsel <= bsel + 2'd1;
      end
    end
  end

  // Select the next output byte
  always_comb begin
    unique case (bsel)
      2'd0:    color_byte = rd_row[7:0];
      2'd1:    color_byte = rd_row[15:8];
      default: color_byte = rd_row[23:16];
    endcase
    stat.row_done = (bsel == 2'd2);
    stat.run_done = (bsel == 2'd2) && (lcnt == N_M1);
    stat.is_set   = action_q;
    stat.fires    = elapsed > {5'd0, limit};
    stat.out_free = !out_valid || out_ready;
    first_next = 1'b0;
    last_next  = 1'b0;
    unique case (cmd.out_sel)
      OUT_REG_COLORS: begin
        byte_next  = REG_COLORS;
        first_next = 1'b1;
      end
      OUT_COLOR: begin
        byte_next = color_byte;
        last_next = stat.run_done;
      end
      OUT_REG_TRANS: begin
        byte_next  = REG_TRANS;
        first_next = 1'b1;
      end
      OUT_TRANS_VALUE: begin
        byte_next = TRANS_VALUE;
        last_next = 1'b1;
      end
      OUT_PREFIX: begin
        byte_next  = CMD_PREFIX;
        first_next = 1'b1;
      end
      OUT_UPDATE: begin
        byte_next = CMD_UPDATE;
        last_next = 1'b1;
      end
      default: byte_next = CMD_PREFIX;
    endcase
  end

  // Output register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_byte  <= byte_next;
      out_first <= first_next;
      out_last  <= last_next;
    end
  end

endmodule

// ===== src/led_color_rotator_sequencer.sv =====
// LED colour rotator sequencer.
// Input stream (s_*): one word per item. s_tuser is the action (0 = poll,
// 1 = set colour); s_tdata carries now, led_number, red, green, blue.
// Output stream (m_*): one word per bus byte; m_tuser marks the first byte
// after the address, m_tlast the final byte of a transaction.
// Configuration (cfg_*): index 0 = update_rate, 1 = ticks_per_second;
// the user must write it only while the block is idle; the block itself does not enforce this.
// Handshake: one item is handled at a time; s_tready is high only when idle.
// A set-colour item or a poll that does not fire goes from idle to the decide
// state and back. A firing poll emits 1 + 3 * NUM_LEDS words (16 for five LEDs),
// one per cycle while the receiver does not stall, paced by the output register.
// A transition or update poll emits 2 words. The colour store is read one LED row per
// three words through a single registered read port.
// Reset restores the five-colour palette (per-row valid bits), the wait
// phase, last firing time zero, update_rate 5 and ticks_per_second 1000.
// A stalled receiver holds the output word; the sequencer waits behind it.
module led_color_rotator_sequencer
  import lcr_pkg::*;
#(
  parameter int NUM_LEDS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // now[31:0], led_number, red, green, blue
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // device_address[6:0], bus_byte[14:7], zero pad
  output logic        m_tuser,   // first_byte
  output logic        m_tlast,   // last
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_wdata
);

  ctl_cmd_t   cmd;
  dp_stat_t   stat;
  logic [7:0] bus_byte;

  lcr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lcr_datapath #(
    .NUM_LEDS (NUM_LEDS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .in_user   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (bus_byte),
    .out_first (m_tuser),
    .out_last  (m_tlast)
  );

  assign m_tdata = {1'b0, bus_byte, DEV_ADDR};

  // A firing poll leaves the block busy for the next cycle
  a_fire_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.fire |=> !s_tready)
    else $error("input accepted right after a firing poll");

  // An opening byte is always a register or command prefix
  a_first_code: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |->
      (bus_byte == REG_COLORS || bus_byte == REG_TRANS || bus_byte == CMD_PREFIX))
    else $error("unexpected opening byte");

  // A word never both opens and closes a transaction
  a_first_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser && m_tlast))
    else $error("word marked both first and last");

  // Loading a new word only when the output slot is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !cmd.out_load)
    else $error("output word overwritten while stalled");

endmodule

// ===== sim/led_color_rotator_sequencer_tb.sv =====
`timescale 1ns / 100ps

module led_color_rotator_sequencer_tb;
  import lcr_pkg::*;

  typedef enum logic {
    ACT_POLL = 1'b0,
    ACT_SET  = 1'b1
  } action_t;

  // One bus word as it leaves the block
  typedef struct packed {
    logic [6:0] address;
    logic [7:0] data;
    logic       first;
    logic       last;
  } bus_word_t;

  localparam int N_LEDS          = 5;
  localparam int STORE_LEN       = 3 * N_LEDS;
  localparam int IDLE_LIMIT      = 5000;
  localparam int SETTLE_CYCLES   = 24;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 37;

  // Reset colours, byte 0 in the low bits (green, red, blue per LED)
  localparam logic [119:0] RESET_COLOURS = {
    8'd64, 8'd30, 8'd64,  8'd5, 8'd85, 8'd5,  8'd30, 8'd0, 8'd0,
    8'd0,  8'd40, 8'd0,   8'd0, 8'd90, 8'd30
  };

  class led_bus_scoreboard;
    logic [7:0]  colours [STORE_LEN];
    logic [31:0] fired_at;
    phase_t      seq_phase;
    logic [2:0]  rate;
    logic [23:0] ticks;
    bus_word_t   due_bytes [$];
    int          errors;

    function new();
      for (int i = 0; i < STORE_LEN; i++) colours[i] = RESET_COLOURS[8*i +: 8];
      fired_at  = '0;
      seq_phase = PH_WAIT;
      rate      = RATE_RESET;
      ticks     = TICKS_RESET;
      errors    = 0;
    endfunction

    function longint unsigned threshold();
      return 64'(ticks) * 64'(rate);
    endfunction

    function void push_word(logic [7:0] data, logic first, logic last);
      bus_word_t w;
      w.address = DEV_ADDR;
      w.data    = data;
      w.first   = first;
      w.last    = last;
      due_bytes.push_back(w);
    endfunction

    // Work out the bus words that one accepted item causes
    function void note_item(action_t act, logic [31:0] now, logic [7:0] led,
                            logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      logic [31:0] elapsed;
      logic [7:0]  keep [3];
      int          base;
      if (act == ACT_SET) begin
        // out-of-range LED numbers are dropped
        if (led >= 8'd1 && led <= 8'(N_LEDS)) begin
          base              = 3 * (int'(led) - 1);
          colours[base]     = green;
          colours[base + 1] = red;
          colours[base + 2] = blue;
        end
      end else if (seq_phase == PH_TRANS) begin
        push_word(REG_TRANS, 1'b1, 1'b0);
        push_word(TRANS_VALUE, 1'b0, 1'b1);
        seq_phase = PH_UPDATE;
      end else if (seq_phase == PH_UPDATE) begin
        push_word(CMD_PREFIX, 1'b1, 1'b0);
        push_word(CMD_UPDATE, 1'b0, 1'b1);
        seq_phase = PH_WAIT;
      end else begin
        // wait phase: fire only on strictly more than the threshold
        elapsed = now - fired_at;
        if (64'(elapsed) > threshold()) begin
          fired_at = now;
          for (int k = 0; k < 3; k++) keep[k] = colours[STORE_LEN - 3 + k];
          for (int i = STORE_LEN - 4; i >= 0; i--) colours[i + 3] = colours[i];
          for (int k = 0; k < 3; k++) colours[k] = keep[k];
          push_word(REG_COLORS, 1'b1, 1'b0);
          for (int k = 0; k < STORE_LEN; k++)
            push_word(colours[k], 1'b0, k == STORE_LEN - 1);
          seq_phase = PH_TRANS;
        end
      end
    endfunction

    // Compare one received word with the oldest expected one
    function void check_byte(bus_word_t got);
      bus_word_t want;
      if (due_bytes.size() == 0) begin
        $error("unexpected bus word: address %0h byte %0h first %0b last %0b",
               got.address, got.data, got.first, got.last);
        errors++;
      end else begin
        want = due_bytes.pop_front();
        if (got.address !== want.address) begin
          $error("device_address: expected %0h, got %0h", want.address, got.address);
          errors++;
        end
        if (got.data !== want.data) begin
          $error("bus_byte: expected %0h, got %0h", want.data, got.data);
          errors++;
        end
        if (got.first !== want.first) begin
          $error("first_byte: expected %0b, got %0b", want.first, got.first);
          errors++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, got.last);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata   = '0;
  logic        s_tuser   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [23:0] cfg_wdata = '0;

  led_bus_scoreboard sb;
  logic steady      = 1'b0;
  int   stall_left  = 0;
  int   idle_cycles = 0;

  led_color_rotator_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 10);
    else return $urandom_range(20, 60);
  endfunction

  // Aim poll times at the firing boundary, with some wide jumps
  function automatic logic [31:0] next_poll_time(logic [31:0] from, longint unsigned thr);
    int unsigned t;
    t = thr[31:0];
    case ($urandom_range(0, 9))
      0:       return from;
      1, 2:    return from + t + $urandom_range(0, 1);
      3, 4, 5: return from + $urandom_range(0, 2 * t + 2);
      6:       return $urandom;
      default: return from + t + 1 + $urandom_range(0, 15);
    endcase
  endfunction

  // Take bus words and stall the output at random
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_byte({m_tdata[6:0], m_tdata[14:7], m_tuser, m_tlast});
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      m_tready <= 1'b0;
      stall_left = pick_gap();
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Offer one item after a random gap, or none in steady mode, and hold it until taken
  task automatic send_item(action_t act, logic [31:0] now, logic [7:0] led,
                           logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {blue, green, red, led, now};
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    sb.note_item(act, now, led, red, green, blue);
  endtask

  task automatic poll(logic [31:0] now);
    send_item(ACT_POLL, now, 8'd0, 8'd0, 8'd0, 8'd0);
  endtask

  // Hold off until every expected word is out, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.due_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [2:0] rate, logic [23:0] ticks);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_UPDATE_RATE;
    cfg_wdata <= {21'd0, rate};
    @(posedge clk);
    cfg_index <= CFG_TICKS;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.rate  = rate;
    sb.ticks = ticks;
  endtask

  initial begin
    logic [7:0] led;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, threshold of 5000 ticks
    poll(32'd0);
    poll(32'd5000);
    send_item(ACT_SET, 32'hFFFFFFFF, 8'd0, 8'hFF, 8'hFF, 8'hFF);
    send_item(ACT_SET, 32'd0, 8'd6, 8'h11, 8'h22, 8'h33);
    send_item(ACT_SET, 32'd0, 8'd255, 8'hFF, 8'hFF, 8'hFF);
    send_item(ACT_SET, 32'd0, 8'd1, 8'hFF, 8'hFF, 8'hFF);
    send_item(ACT_SET, 32'd0, 8'd5, 8'h00, 8'h00, 8'h00);
    poll(32'd5001);
    send_item(ACT_SET, 32'd0, 8'd3, 8'hA5, 8'h5A, 8'hC3);
    poll(32'd0);
    poll(32'd0);
    poll(32'd10001);
    poll(32'hFFFFFFFF);
    poll(32'd0);
    poll(32'd0);
    poll(32'h00000000);
    poll(32'h80001387);
    poll(32'd7);
    poll(32'd7);
    send_item(ACT_SET, 32'd0, 8'd2, 8'h12, 8'h34, 8'h56);
    send_item(ACT_SET, 32'd0, 8'd4, 8'hFE, 8'h01, 8'h80);
    poll(32'h80001387 + 32'd5001);
    poll(32'd0);
    poll(32'd0);
    drain();

    // Random phases, each under its own settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       write_regs(3'd0, 24'd1);
        1:       write_regs(3'd5, 24'hFFFFFF);
        2:       write_regs(3'd1, 24'd1);
        3:       write_regs(3'd7, 24'($urandom_range(1, 40)));
        4:       write_regs(3'($urandom_range(1, 5)), 24'($urandom));
        default: write_regs(RATE_RESET, TICKS_RESET);
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 12 == 0) steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) == 0) begin
          led = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 6)) : 8'($urandom);
          send_item(ACT_SET, $urandom, led, 8'($urandom), 8'($urandom), 8'($urandom));
        end else begin
          send_item(ACT_POLL, next_poll_time(sb.fired_at, sb.threshold()),
                    8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
        if ($urandom_range(0, 24) == 0) drain();
      end
      drain();
    end

    if (sb.errors == 0 && sb.due_bytes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
